### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for clocked concurrent assertions with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk_sig, rst_sig, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(expr)) \
    else $error(msg);

`endif

### hw/rtl/mfb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_pkg
// Shared constants and types of the mono framebuffer page refresh core.
// ---------------------------------------------------------------------------
package mfb_pkg;

  // field widths of the request and result
  localparam int ADDR_W = 10;
  localparam int DATA_W = 8;

  // job fields sized for the largest geometry allowed
  localparam int PAGE_W = 4;
  localparam int COL_W  = 8;

  // default geometry
  localparam int DEF_WIDTH      = 128;
  localparam int DEF_PAGES      = 8;
  localparam int DEF_LINE_BYTES = 16;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EMIT  = 1'b1;

  // refresh stream bytes
  localparam int                HEADER_LEN   = 7;
  localparam logic [DATA_W-1:0] CMD_PREFIX   = 8'h00;
  localparam logic [DATA_W-1:0] DATA_PREFIX  = 8'h40;
  localparam logic [DATA_W-1:0] PAGE_CMD     = 8'hb0;
  localparam logic [DATA_W-1:0] COL_HIGH_CMD = 8'h10;
  localparam logic [DATA_W-1:0] COL_LOW_CMD  = 8'h00;

  // positions inside the command header
  localparam int POS_PAGE_CMD = 1;
  localparam int POS_COL_HIGH = 3;
  localparam int POS_DATA_PFX = 6;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    JOB_WRITE  = 2'd0,
    JOB_CONST  = 2'd1,
    JOB_COLUMN = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [ADDR_W-1:0] addr;   // store address for a write
    logic [DATA_W-1:0] data;   // write data, or the byte of a header job
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic              first;
    logic              last;
    logic              frame;
  } job_t;

endpackage

### hw/rtl/mfb_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_front
// Takes requests, tracks page and stream position, and turns each request
// into a store write, a header byte or a column gather job.
// ---------------------------------------------------------------------------
module mfb_front #(
  parameter int WIDTH = mfb_pkg::DEF_WIDTH,
  parameter int PAGES = mfb_pkg::DEF_PAGES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [mfb_pkg::ADDR_W-1:0]  fb_address,
  input  logic [mfb_pkg::DATA_W-1:0]  fb_data,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        q_push,
  output mfb_pkg::job_t               q_job
);
  import mfb_pkg::*;

  localparam int PW       = $clog2(WIDTH + HEADER_LEN);
  localparam int PGW      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LAST_POS = HEADER_LEN + WIDTH - 1;

  logic [PW-1:0]  position;
  logic [PGW-1:0] page;
  logic           accept;

  assign in_stall = q_full | clearing;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept;

  always_comb begin
    q_job.kind  = JOB_WRITE;
    q_job.addr  = fb_address;
    q_job.data  = fb_data;
    q_job.page  = PAGE_W'(page);
    q_job.col   = COL_W'(position - PW'(HEADER_LEN));
    q_job.first = 1'b0;
    q_job.last  = 1'b0;
    q_job.frame = 1'b0;
    if (req_type == REQ_EMIT) begin
      if (position < PW'(HEADER_LEN)) begin
        q_job.kind = JOB_CONST;
        if (!position[0]) begin
          // command prefix, or the data prefix at the end of the header
          q_job.first = 1'b1;
          q_job.data  = (position == PW'(POS_DATA_PFX)) ? DATA_PREFIX : CMD_PREFIX;
        end else begin
          q_job.last = 1'b1;
          if (position == PW'(POS_PAGE_CMD)) begin
            q_job.data = PAGE_CMD + DATA_W'(page);
          end else if (position == PW'(POS_COL_HIGH)) begin
            q_job.data = COL_HIGH_CMD;
          end else begin
            q_job.data = COL_LOW_CMD;
          end
        end
      end else begin
        q_job.kind = JOB_COLUMN;
        if (position == PW'(LAST_POS)) begin
          q_job.last  = 1'b1;
          q_job.frame = (page == PGW'(PAGES - 1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      page     <= '0;
    end else if (accept && req_type == REQ_EMIT) begin
      if (position == PW'(LAST_POS)) begin
        position <= '0;
        page     <= (page == PGW'(PAGES - 1)) ? '0 : page + 1'b1;
      end else begin
        position <= position + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/mfb_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_queue
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module mfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mfb_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output mfb_pkg::job_t q_job,
  output logic          full
);
  import mfb_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  job_t           slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;

  assign q_valid = (count != '0);
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_job   = slots[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/mfb_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_back
// Owns the frame store: clears it after reset, applies writes, gathers
// column bytes one row read at a time and holds the result register.
// ---------------------------------------------------------------------------
module mfb_back #(
  parameter int WIDTH      = mfb_pkg::DEF_WIDTH,
  parameter int PAGES      = mfb_pkg::DEF_PAGES,
  parameter int LINE_BYTES = mfb_pkg::DEF_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  mfb_pkg::job_t               q_job,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mfb_pkg::DATA_W-1:0]  link_byte,
  output logic                        first_of_transfer,
  output logic                        last_of_transfer,
  output logic                        last_of_frame
);
  import mfb_pkg::*;

  localparam int STORE_BYTES = PAGES * 8 * LINE_BYTES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int XW          = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam int RW          = $clog2(STORE_BYTES + WIDTH / 8 + 8 * LINE_BYTES) + 1;
  localparam int PAGE_STEP   = 8 * LINE_BYTES;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     clr_addr;
  logic [3:0]        cnt;
  logic [RW-1:0]     rd_addr;
  logic              rd_ok;
  logic [2:0]        bit_sel;
  logic [DATA_W-1:0] acc;
  logic              last_q;
  logic              frame_q;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] mem [STORE_BYTES];

  logic              out_free;
  logic [XW-1:0]     wr_x;
  logic              wr_ok;
  logic [RW-1:0]     base;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              load_out;
  logic [DATA_W-1:0] load_byte;
  logic              load_first;
  logic              load_last;
  logic              load_frame;

  assign clearing = (state == S_CLEAR);
  assign out_free = ~out_valid | ~out_stall;
  assign wr_x     = XW'(q_job.addr);
  assign wr_ok    = (wr_x < XW'(STORE_BYTES));
  // address of the first row of the page at this column
  assign base     = RW'(q_job.page) * RW'(PAGE_STEP) + RW'(q_job.col >> 3);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    load_out   = 1'b0;
    load_byte  = q_job.data;
    load_first = q_job.first;
    load_last  = q_job.last;
    load_frame = q_job.frame;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(STORE_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_job.kind)
            JOB_WRITE: begin
              q_pop     = 1'b1;
              mem_we    = wr_ok;
              mem_waddr = wr_x[AW-1:0];
              mem_wdata = q_job.data;
            end
            JOB_CONST: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_out = 1'b1;
              end
            end
            JOB_COLUMN: begin
              q_pop      = 1'b1;
              state_next = S_READ;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (cnt == 4'd8) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        load_byte  = acc;
        load_first = 1'b0;
        load_last  = last_q;
        load_frame = frame_q;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_IDLE && q_valid && q_job.kind == JOB_COLUMN) begin
        cnt <= '0;
      end else if (state == S_READ) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // gather datapath: one row read issued per cycle, bit picked from the registered read data
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_job.kind == JOB_COLUMN) begin
      rd_addr <= base;
      bit_sel <= q_job.col[2:0];
      last_q  <= q_job.last;
      frame_q <= q_job.frame;
    end else if (state == S_READ) begin
      rd_addr <= rd_addr + RW'(LINE_BYTES);
    end
    rd_ok <= (rd_addr < RW'(STORE_BYTES));
    if (state == S_READ && cnt != '0) begin
      acc <= {rd_ok & rdata[bit_sel], acc[DATA_W-1:1]};
    end
    if (load_out) begin
      link_byte         <= load_byte;
      first_of_transfer <= load_first;
      last_of_transfer  <= load_last;
      last_of_frame     <= load_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr[AW-1:0]];
  end

endmodule

### hw/rtl/mono_framebuffer_page_refresh_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mono_framebuffer_page_refresh_core
// One-bit framebuffer with a page-mode refresh byte stream.
// ---------------------------------------------------------------------------
// A write request stores one framebuffer byte and gives no result; an emit
// request gives the next byte of the refresh stream (three two-byte command
// transfers, then a data prefix and one column byte per display column, page
// after page). Requests pass through a two-entry queue to the store unit.
// A write is applied to the store when the store unit takes it, and a header
// byte is loaded into the output register once the output is free. A column
// byte is started, gathered by eight row reads through the store's single read
// port (the read data is registered before its bit is taken) and then loaded
// into the output. After reset the store's PAGES*8*LINE_BYTES bytes (1024 at
// the default size) are cleared one byte per cycle, and in_stall stays high
// until that pass is done.
`include "assert_macros.svh"

module mono_framebuffer_page_refresh_core #(
  parameter int WIDTH      = mfb_pkg::DEF_WIDTH,
  parameter int PAGES      = mfb_pkg::DEF_PAGES,
  parameter int LINE_BYTES = mfb_pkg::DEF_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [mfb_pkg::ADDR_W-1:0]  fb_address,
  input  logic [mfb_pkg::DATA_W-1:0]  fb_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mfb_pkg::DATA_W-1:0]  link_byte,
  output logic                        first_of_transfer,
  output logic                        last_of_transfer,
  output logic                        last_of_frame
);
  import mfb_pkg::*;

  logic q_push;
  job_t push_job;
  logic q_pop;
  logic q_valid;
  job_t q_job;
  logic q_full;
  logic clearing;

  mfb_front #(
    .WIDTH (WIDTH),
    .PAGES (PAGES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .fb_address (fb_address),
    .fb_data    (fb_data),
    .q_full     (q_full),
    .clearing   (clearing),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  mfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .full     (q_full)
  );

  mfb_back #(
    .WIDTH      (WIDTH),
    .PAGES      (PAGES),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_job             (q_job),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .link_byte         (link_byte),
    .first_of_transfer (first_of_transfer),
    .last_of_transfer  (last_of_transfer),
    .last_of_frame     (last_of_frame)
  );

  // no request may enter while the store is being cleared
  `ASSERT_ALWAYS(a_stall_in_clear, clk, rst, clearing |-> in_stall, "request taken during clear")
  `ASSERT_NEVER(a_push_full, clk, rst, q_push && q_full, "queue pushed while full")
  `ASSERT_ALWAYS(a_pop_valid, clk, rst, q_pop |-> q_valid, "queue popped while empty")
  // frame end only ever marks the last byte of a transfer
  `ASSERT_ALWAYS(a_frame_last, clk, rst, (out_valid && last_of_frame) |-> last_of_transfer,
    "frame end without transfer end")

endmodule
